// File: src/hfsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfsc_pkg
// Shared types and codes for the host field syntax checker.
// ----------------------------------------------------------------------------
package hfsc_pkg;

  // Result form codes
  localparam logic [1:0] FORM_NONE = 2'd0;
  localparam logic [1:0] FORM_HOST = 2'd1;
  localparam logic [1:0] FORM_IPV4 = 2'd2;
  localparam logic [1:0] FORM_IPV6 = 2'd3;

  // One byte handed from the input register to the recognizers
  typedef struct packed {
    logic       step;
    logic [7:0] char_byte;
    logic       last_byte;
  } step_t;

  // Verdict for a finished string
  typedef struct packed {
    logic       host_valid;
    logic [1:0] matched_form;
  } verdict_t;

endpackage
`default_nettype wire

// File: src/hfsc_recog.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfsc_recog
// Hostname, IPv4 and IPv6 recognizers running side by side on one byte per
// step; the verdict is formed combinationally from the updated state.
// ----------------------------------------------------------------------------
module hfsc_recog (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire hfsc_pkg::step_t  step_in,
  output hfsc_pkg::verdict_t    verdict
);

  localparam logic [6:0] HOST_MAX_LEN = 7'd63;
  localparam logic [6:0] COUNT_SAT    = 7'd64;
  localparam logic [3:0] PREFIX_DONE  = 4'd15;
  localparam logic [3:0] ZERO_LAST    = 4'd11;
  localparam logic [3:0] FFFF_LAST    = 4'd14;
  localparam logic [3:0] ZERO_LEN     = 4'd12;

  // label phase codes
  localparam logic [1:0] LBL_START  = 2'd0;
  localparam logic [1:0] LBL_ALNUM  = 2'd1;
  localparam logic [1:0] LBL_HYPHEN = 2'd2;

  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_HYPHEN = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_F      = 8'h46;

  typedef struct packed {
    logic [1:0] grp;
    logic [1:0] dig;
    logic       alive;
  } quad_t;

  function automatic logic is_dig(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_dig(c) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  function automatic quad_t quad_feed(quad_t q, logic [7:0] c);
    quad_t r;
    r = q;
    if (q.alive) begin
      if (is_dig(c)) begin
        if (q.dig == 2'd3) r.alive = 1'b0;
        else r.dig = q.dig + 2'd1;
      end else if (c == CH_DOT) begin
        if ((q.dig == 2'd0) || (q.grp == 2'd3)) begin
          r.alive = 1'b0;
        end else begin
          r.grp = q.grp + 2'd1;
          r.dig = 2'd0;
        end
      end else begin
        r.alive = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic logic quad_ok(quad_t q);
    return q.alive && (q.grp == 2'd3) && (q.dig != 2'd0);
  endfunction

  // "0:0:0:0:0:0:"
  function automatic logic [7:0] zero_char(logic [3:0] pos);
    return pos[0] ? CH_COLON : CH_ZERO;
  endfunction

  // "0:0:0:0:0:FFFF:"
  function automatic logic [7:0] ffff_char(logic [3:0] pos);
    logic [7:0] ch;
    case (pos)
      4'd10, 4'd11, 4'd12, 4'd13: ch = CH_F;
      4'd14:                      ch = CH_COLON;
      default:                    ch = pos[0] ? CH_COLON : CH_ZERO;
    endcase
    return ch;
  endfunction

  logic [6:0] byte_count_r, byte_count_nxt;
  logic [1:0] label_phase_r, label_phase_nxt;
  logic       host_alive_r, host_alive_nxt;
  quad_t      quad_r, quad_nxt;
  logic [2:0] hex_group_r, hex_group_nxt;
  logic       hex_seen_r, hex_seen_nxt;
  logic       hex_alive_r, hex_alive_nxt;
  logic [1:0] seen_dc_r, seen_dc_nxt;
  logic [3:0] pfx_pos_r, pfx_pos_nxt;
  logic [1:0] pfx_cand_r, pfx_cand_nxt;
  quad_t      tail_r, tail_nxt;

  logic [7:0] c;
  logic       cand_zero, cand_ffff;
  logic       host_ok, v4_ok, v6_ok;

  assign c = step_in.char_byte;

  always_comb begin
    byte_count_nxt  = byte_count_r;
    label_phase_nxt = label_phase_r;
    host_alive_nxt  = host_alive_r;
    hex_group_nxt   = hex_group_r;
    hex_seen_nxt    = hex_seen_r;
    hex_alive_nxt   = hex_alive_r;
    seen_dc_nxt     = seen_dc_r;
    pfx_pos_nxt     = pfx_pos_r;
    pfx_cand_nxt    = pfx_cand_r;
    tail_nxt        = tail_r;
    cand_zero       = 1'b0;
    cand_ffff       = 1'b0;

    if (c == CH_DOT)   seen_dc_nxt[0] = 1'b1;
    if (c == CH_COLON) seen_dc_nxt[1] = 1'b1;

    // hostname
    if (byte_count_r < COUNT_SAT) byte_count_nxt = byte_count_r + 7'd1;
    if (host_alive_r) begin
      if (is_alpha(c) || is_dig(c)) begin
        label_phase_nxt = LBL_ALNUM;
      end else if (c == CH_HYPHEN) begin
        if (label_phase_r == LBL_START) host_alive_nxt = 1'b0;
        else label_phase_nxt = LBL_HYPHEN;
      end else if (c == CH_DOT) begin
        if (label_phase_r != LBL_ALNUM) host_alive_nxt = 1'b0;
        else label_phase_nxt = LBL_START;
      end else begin
        host_alive_nxt = 1'b0;
      end
    end

    // IPv4
    quad_nxt = quad_feed(quad_r, c);

    // IPv6 pure hex form
    if (hex_alive_r) begin
      if (is_hex(c)) begin
        hex_seen_nxt = 1'b1;
      end else if (c == CH_COLON) begin
        if (!hex_seen_r || (hex_group_r == 3'd7)) begin
          hex_alive_nxt = 1'b0;
        end else begin
          hex_group_nxt = hex_group_r + 3'd1;
          hex_seen_nxt  = 1'b0;
        end
      end else begin
        hex_alive_nxt = 1'b0;
      end
    end

    // IPv6 prefix followed by dotted quad
    if (pfx_cand_r != 2'b00) begin
      if (pfx_pos_r == PREFIX_DONE) begin
        tail_nxt = quad_feed(tail_r, c);
      end else begin
        cand_zero = pfx_cand_r[0] && (pfx_pos_r < ZERO_LEN) && (zero_char(pfx_pos_r) == c);
        cand_ffff = pfx_cand_r[1] && (ffff_char(pfx_pos_r) == c);
        pfx_cand_nxt = {cand_ffff, cand_zero};
        if (cand_zero && (pfx_pos_r == ZERO_LAST)) begin
          pfx_cand_nxt = 2'b01;
          pfx_pos_nxt  = PREFIX_DONE;
        end else if (cand_ffff && (pfx_pos_r == FFFF_LAST)) begin
          pfx_cand_nxt = 2'b10;
          pfx_pos_nxt  = PREFIX_DONE;
        end else if (cand_zero || cand_ffff) begin
          pfx_pos_nxt = pfx_pos_r + 4'd1;
        end
      end
    end
  end

  always_comb begin
    host_ok = host_alive_nxt && (label_phase_nxt == LBL_ALNUM) &&
              (byte_count_nxt <= HOST_MAX_LEN);
    v4_ok   = !seen_dc_nxt[1] && quad_ok(quad_nxt);
    v6_ok   = seen_dc_nxt[1] &&
              ((seen_dc_nxt[0] && (pfx_pos_nxt == PREFIX_DONE) &&
                (pfx_cand_nxt != 2'b00) && quad_ok(tail_nxt)) ||
               (!seen_dc_nxt[0] && hex_alive_nxt && (hex_group_nxt == 3'd7) &&
                hex_seen_nxt));
    if (host_ok)    verdict.matched_form = hfsc_pkg::FORM_HOST;
    else if (v4_ok) verdict.matched_form = hfsc_pkg::FORM_IPV4;
    else if (v6_ok) verdict.matched_form = hfsc_pkg::FORM_IPV6;
    else            verdict.matched_form = hfsc_pkg::FORM_NONE;
    verdict.host_valid = host_ok || v4_ok || v6_ok;
  end

  // Advance on each step; drop back to the start state after the final byte.
  always_ff @(posedge clk) begin
    if (!rst_n || (step_in.step && step_in.last_byte)) begin
      byte_count_r  <= '0;
      label_phase_r <= LBL_START;
      host_alive_r  <= 1'b1;
      quad_r        <= '{grp: 2'd0, dig: 2'd0, alive: 1'b1};
      hex_group_r   <= '0;
      hex_seen_r    <= 1'b0;
      hex_alive_r   <= 1'b1;
      seen_dc_r     <= '0;
      pfx_pos_r     <= '0;
      pfx_cand_r    <= 2'b11;
      tail_r        <= '{grp: 2'd0, dig: 2'd0, alive: 1'b1};
    end else if (step_in.step) begin
      byte_count_r  <= byte_count_nxt;
      label_phase_r <= label_phase_nxt;
      host_alive_r  <= host_alive_nxt;
      quad_r        <= quad_nxt;
      hex_group_r   <= hex_group_nxt;
      hex_seen_r    <= hex_seen_nxt;
      hex_alive_r   <= hex_alive_nxt;
      seen_dc_r     <= seen_dc_nxt;
      pfx_pos_r     <= pfx_pos_nxt;
      pfx_cand_r    <= pfx_cand_nxt;
      tail_r        <= tail_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= COUNT_SAT)
    else $error("byte count above saturation");

  a_prefix_done_one: assert property (@(posedge clk) disable iff (!rst_n)
    (pfx_pos_r == PREFIX_DONE) |-> $onehot(pfx_cand_r))
    else $error("finished prefix without exactly one candidate");

  a_string_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (step_in.step && step_in.last_byte) |=> (byte_count_r == 7'd0) && host_alive_r)
    else $error("recognizers not restarted after final byte");
`endif

endmodule
`default_nettype wire

// File: src/host_field_syntax_checker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// host_field_syntax_checker_top
// Byte-stream checker for the host field: hostname, IPv4 or IPv6 syntax.
// ----------------------------------------------------------------------------
// Accepts one byte of a host string per cycle while in_stall is low, with
// in_last_byte marking the final byte, and emits one transaction per string:
// out_host_valid and the matched form (hostname has priority over IPv4, then
// IPv6). Bytes can enter back to back at one per clock unless stalled; each
// byte is registered, folded into the recognizer flags and counters, and the
// verdict for the final byte is captured in the output register behind
// out_valid. A stall on the result side only backs up the input once a second
// final byte is waiting behind an untaken result.
module host_field_syntax_checker_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_byte,
  input  wire logic       in_last_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_host_valid,
  output logic [1:0]      out_matched_form
);

  logic               s1_valid_r, s1_valid_nxt;
  logic [7:0]         s1_char_r;
  logic               s1_last_r;
  logic               s1_adv;
  logic               in_acc;
  logic               out_valid_r, out_valid_nxt;
  logic               out_host_valid_r;
  logic [1:0]         out_form_r;
  hfsc_pkg::step_t    step;
  hfsc_pkg::verdict_t verdict;

  // A non-final byte never waits; a final byte needs room in the result register.
  assign s1_adv   = !s1_last_r || !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign step.step      = s1_valid_r && s1_adv;
  assign step.char_byte = s1_char_r;
  assign step.last_byte = s1_last_r;

  hfsc_recog u_recog (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_in (step),
    .verdict (verdict)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (step.step && s1_last_r) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_char_byte;
      s1_last_r <= in_last_byte;
    end
    if (step.step && s1_last_r) begin
      out_host_valid_r <= verdict.host_valid;
      out_form_r       <= verdict.matched_form;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_host_valid   = out_host_valid_r;
  assign out_matched_form = out_form_r;

`ifndef SYNTHESIS
  a_valid_form_agree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_host_valid_r == (out_form_r != hfsc_pkg::FORM_NONE)))
    else $error("host_valid disagrees with matched form");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid_r))
    else $error("input stalled without a blocked final byte");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || !out_stall) && !(s1_valid_r && s1_last_r) |=> !out_valid_r)
    else $error("result appeared without a final byte");
`endif

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for host_field_syntax_checker_top. A table of host
// strings (hostname, IPv4, both IPv6 forms and broken variants) runs first,
// followed by random well-formed, mutated and noise strings. A byte-level
// predictor of the three recognizers supplies the expected verdicts for the
// random strings and the BY_MODEL rows. Sender bursts and receiver stalls are
// randomized throughout.
module tb_top;

  localparam int         IDLE_LIMIT   = 4000;
  localparam int         DRAIN_CYCLES = 16;
  localparam int         RANDOM_BYTES = 500;
  localparam int         BY_MODEL     = -1;
  localparam logic [3:0] PFX_DONE     = 4'd15;
  localparam logic [6:0] HOST_MAX_LEN = 7'd63;
  localparam logic [8*12-1:0] V6_ZERO_PFX = "0:0:0:0:0:0:";
  localparam logic [8*15-1:0] V6_FFFF_PFX = "0:0:0:0:0:FFFF:";
  // class boundaries: around digits, letters and hex letters
  localparam logic [8*12-1:0] EDGE_CHARS  = "/:@[`{Gg.-9Z";

  typedef enum logic [1:0] {LBL_START, LBL_ALNUM, LBL_HYPHEN} label_phase_t;

  logic       clk;
  logic       rst_n            = 1'b0;
  logic       in_valid         = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_byte     = 8'd0;
  logic       in_last_byte     = 1'b0;
  logic       out_valid;
  logic       out_stall        = 1'b0;
  logic       out_host_valid;
  logic [1:0] out_matched_form;

  host_field_syntax_checker_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_host_valid   (out_host_valid),
    .out_matched_form (out_matched_form)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Directed strings; BY_MODEL rows are checked against the predictor
  string dir_text [22] = '{
    "a", "0zZ9", "a-b.c-d", "a--b", "-a", "a-", "a..b", ".a", "a.",
    "1.2.3.4", "255.0.0.255", "1:2:3:4:5:6:7:8", "FFFF:0:ABCDEF012:1:2:3:4:5",
    "0:0:0:0:0:0:1.2.3.4", "0:0:0:0:0:FFFF:10.0.0.1", "0:0:0:0:0:FFFF:1.2.3",
    "1:2:3:4:5:6:7", "1::3:4:5:6:7:8", "a:b:c:d:e:f:1:2", "\377", "a\200",
    "1.2.3.4:"
  };
  int dir_form [22] = '{
    hfsc_pkg::FORM_HOST, hfsc_pkg::FORM_HOST, hfsc_pkg::FORM_HOST, hfsc_pkg::FORM_HOST,
    hfsc_pkg::FORM_NONE, hfsc_pkg::FORM_NONE, hfsc_pkg::FORM_NONE, hfsc_pkg::FORM_NONE,
    hfsc_pkg::FORM_NONE, hfsc_pkg::FORM_HOST, hfsc_pkg::FORM_HOST, hfsc_pkg::FORM_IPV6,
    BY_MODEL, BY_MODEL, BY_MODEL, BY_MODEL,
    hfsc_pkg::FORM_NONE, hfsc_pkg::FORM_NONE, hfsc_pkg::FORM_NONE, hfsc_pkg::FORM_NONE,
    hfsc_pkg::FORM_NONE, BY_MODEL
  };

  // Predictor state
  logic [6:0]   hs_count;
  label_phase_t hs_label;
  bit           hs_host_live;
  logic [1:0]   hs_qgrp, hs_qdig;
  bit           hs_qlive;
  logic [2:0]   hs_hgrp;
  bit           hs_hdig, hs_hlive;
  bit           hs_dot, hs_colon;
  logic [3:0]   hs_ppos;
  logic [1:0]   hs_pcand;
  logic [1:0]   hs_tgrp, hs_tdig;
  bit           hs_tlive;

  hfsc_pkg::verdict_t verdict_q[$];
  logic [7:0]         host_text[$];

  int fail_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int bytes_sent = 0;
  int strings_sent = 0;
  int n_none = 0, n_host = 0, n_ipv4 = 0, n_ipv6 = 0;
  int stall_mode = 0, stall_left = 0;

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= "A" && c <= "F");
  endfunction

  task automatic clear_host_state();
    hs_count = '0;  hs_label = LBL_START; hs_host_live = 1'b1;
    hs_qgrp = '0;   hs_qdig = '0;         hs_qlive = 1'b1;
    hs_hgrp = '0;   hs_hdig = 1'b0;       hs_hlive = 1'b1;
    hs_dot = 1'b0;  hs_colon = 1'b0;
    hs_ppos = '0;   hs_pcand = 2'b11;
    hs_tgrp = '0;   hs_tdig = '0;         hs_tlive = 1'b1;
  endtask

  task automatic dotted_quad_step(inout logic [1:0] grp, inout logic [1:0] dig,
                                  inout bit alive, input logic [7:0] c);
    if (!alive) return;
    if (is_digit(c)) begin
      if (dig == 2'd3) alive = 1'b0;
      else dig = dig + 2'd1;
    end else if (c == ".") begin
      if (dig == 2'd0 || grp == 2'd3) alive = 1'b0;
      else begin
        grp = grp + 2'd1;
        dig = 2'd0;
      end
    end else begin
      alive = 1'b0;
    end
  endtask

  task automatic v6_prefix_step(input logic [7:0] c);
    if (hs_pcand == 2'b00) return;
    if (hs_ppos == PFX_DONE) begin
      dotted_quad_step(hs_tgrp, hs_tdig, hs_tlive, c);
      return;
    end
    if (hs_pcand[0] && (hs_ppos >= 4'd12 || V6_ZERO_PFX[8*(11-hs_ppos) +: 8] != c))
      hs_pcand[0] = 1'b0;
    if (hs_pcand[1] && (hs_ppos >= 4'd15 || V6_FFFF_PFX[8*(14-hs_ppos) +: 8] != c))
      hs_pcand[1] = 1'b0;
    if (hs_pcand == 2'b00) return;
    if (hs_pcand[0] && hs_ppos == 4'd11) begin
      hs_pcand = 2'b01;
      hs_ppos = PFX_DONE;
    end else if (hs_pcand[1] && hs_ppos == 4'd14) begin
      hs_pcand = 2'b10;
      hs_ppos = PFX_DONE;
    end else begin
      hs_ppos = hs_ppos + 4'd1;
    end
  endtask

  // Advance all recognizers by one byte; on the final byte produce the verdict
  task automatic fold_host_byte(input logic [7:0] c, input logic last,
                                output bit done, output hfsc_pkg::verdict_t v);
    bit host_ok, v4_ok, v6_ok;
    done = 1'b0;
    v = '0;
    if (c == ".") hs_dot = 1'b1;
    if (c == ":") hs_colon = 1'b1;
    if (hs_count < 7'd64) hs_count = hs_count + 7'd1;
    if (hs_host_live) begin
      if (is_alpha(c) || is_digit(c)) hs_label = LBL_ALNUM;
      else if (c == "-") begin
        if (hs_label == LBL_START) hs_host_live = 1'b0;
        else hs_label = LBL_HYPHEN;
      end else if (c == ".") begin
        if (hs_label != LBL_ALNUM) hs_host_live = 1'b0;
        else hs_label = LBL_START;
      end else hs_host_live = 1'b0;
    end
    dotted_quad_step(hs_qgrp, hs_qdig, hs_qlive, c);
    if (hs_hlive) begin
      if (is_hex(c)) hs_hdig = 1'b1;
      else if (c == ":") begin
        if (!hs_hdig || hs_hgrp == 3'd7) hs_hlive = 1'b0;
        else begin
          hs_hgrp = hs_hgrp + 3'd1;
          hs_hdig = 1'b0;
        end
      end else hs_hlive = 1'b0;
    end
    v6_prefix_step(c);
    if (!last) return;

    host_ok = hs_host_live && hs_label == LBL_ALNUM && hs_count <= HOST_MAX_LEN;
    v4_ok = !hs_colon && hs_qlive && hs_qgrp == 2'd3 && hs_qdig != 2'd0;
    v6_ok = hs_colon &&
            ((hs_dot && hs_ppos == PFX_DONE && hs_pcand != 2'b00 &&
              hs_tlive && hs_tgrp == 2'd3 && hs_tdig != 2'd0) ||
             (!hs_dot && hs_hlive && hs_hgrp == 3'd7 && hs_hdig));
    if (host_ok)    v.matched_form = hfsc_pkg::FORM_HOST;
    else if (v4_ok) v.matched_form = hfsc_pkg::FORM_IPV4;
    else if (v6_ok) v.matched_form = hfsc_pkg::FORM_IPV6;
    else            v.matched_form = hfsc_pkg::FORM_NONE;
    v.host_valid = (v.matched_form != hfsc_pkg::FORM_NONE);
    done = 1'b1;
    clear_host_state();
  endtask

  // Result check, receiver stall pattern and watchdog
  always @(posedge clk) begin : result_mon
    hfsc_pkg::verdict_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result: host_valid=%0b matched_form=%0d",
                 out_host_valid, out_matched_form);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_host_valid !== want.host_valid) begin
            $error("host_valid: expected %0b, got %0b", want.host_valid, out_host_valid);
            fail_count++;
          end
          if (out_matched_form !== want.matched_form) begin
            $error("matched_form: expected %0d, got %0d", want.matched_form, out_matched_form);
            fail_count++;
          end
          case (want.matched_form)
            hfsc_pkg::FORM_HOST: n_host++;
            hfsc_pkg::FORM_IPV4: n_ipv4++;
            hfsc_pkg::FORM_IPV6: n_ipv6++;
            default:             n_none++;
          endcase
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: no transaction for %0d cycles", IDLE_LIMIT);
        $display("tb_top: errors");
        $finish;
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 150);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 1) != 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_left % 3 == 0);
    endcase
  end

  // Present one byte and hold it until accepted
  task automatic send_byte(input logic [7:0] c, input logic last, input int typed_form);
    int gap;
    bit done;
    hfsc_pkg::verdict_t v;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_char_byte <= c;
    in_last_byte <= last;
    do @(posedge clk); while (!(in_valid && !in_stall));
    bytes_sent++;
    fold_host_byte(c, last, done, v);
    if (done) begin
      if (typed_form != BY_MODEL) begin
        v.matched_form = typed_form[1:0];
        v.host_valid = (typed_form != hfsc_pkg::FORM_NONE);
      end
      verdict_q.push_back(v);
      strings_sent++;
    end
  endtask

  task automatic send_text(input int typed_form);
    foreach (host_text[i])
      send_byte(host_text[i], i == host_text.size() - 1, typed_form);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (verdict_q.size() != 0);
  endtask

  function automatic logic [7:0] pick_alnum();
    logic [7:0] ch;
    case ($urandom_range(0, 2))
      0:       ch = 8'(8'h30 + $urandom_range(0, 9));
      1:       ch = 8'(8'h41 + $urandom_range(0, 25));
      default: ch = 8'(8'h61 + $urandom_range(0, 25));
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] pick_noise();
    logic [7:0] ch;
    if ($urandom_range(0, 1) == 0) ch = 8'($urandom_range(0, 255));
    else ch = EDGE_CHARS[8*$urandom_range(0, 11) +: 8];
    return ch;
  endfunction

  task automatic add_label(input int len);
    for (int i = 0; i < len; i++) begin
      if (i == 0 || i == len - 1 || $urandom_range(0, 3) != 0) host_text.push_back(pick_alnum());
      else host_text.push_back("-");
    end
  endtask

  task automatic add_dotted_quad();
    int groups, len;
    logic [7:0] ch;
    groups = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 5) : 4;
    for (int g = 0; g < groups; g++) begin
      if (g > 0) host_text.push_back(".");
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : $urandom_range(1, 3);
      repeat (len) begin
        ch = 8'(8'h30 + $urandom_range(0, 9));
        host_text.push_back(ch);
      end
    end
  endtask

  task automatic add_hex_groups();
    int groups, len, d;
    logic [7:0] ch;
    groups = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 9) : 8;
    for (int g = 0; g < groups; g++) begin
      if (g > 0) host_text.push_back(":");
      len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 5);
      repeat (len) begin
        d = $urandom_range(0, 15);
        if (d < 10) ch = 8'(8'h30 + d);
        else if ($urandom_range(0, 9) == 0) ch = 8'(8'h61 + d - 10);
        else ch = 8'(8'h41 + d - 10);
        host_text.push_back(ch);
      end
    end
  endtask

  task automatic add_v6_dotted();
    if ($urandom_range(0, 1) == 0)
      for (int i = 11; i >= 0; i--) host_text.push_back(V6_ZERO_PFX[8*i +: 8]);
    else
      for (int i = 14; i >= 0; i--) host_text.push_back(V6_FFFF_PFX[8*i +: 8]);
    add_dotted_quad();
  endtask

  task automatic add_long_hostname();
    int target;
    target = $urandom_range(60, 66);
    if ($urandom_range(0, 1) == 0) begin
      add_label(target);
    end else begin
      while (host_text.size() < target) begin
        if (host_text.size() > 0) host_text.push_back(".");
        add_label($urandom_range(1, 12));
      end
    end
  endtask

  task automatic mutate_text();
    int pos;
    pos = $urandom_range(0, host_text.size() - 1);
    case ($urandom_range(0, 2))
      0: host_text[pos] = pick_noise();
      1: if (host_text.size() > 1) host_text.delete(pos);
      default: host_text.insert(pos, pick_noise());
    endcase
  endtask

  initial begin : stimulus
    int random_start, kind;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    clear_host_state();

    for (int i = 0; i < 22; i++) begin
      host_text.delete();
      for (int k = 0; k < dir_text[i].len(); k++) host_text.push_back(dir_text[i][k]);
      send_text(dir_form[i]);
    end
    hold_until_drained();

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      host_text.delete();
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        repeat ($urandom_range(1, 4)) begin
          if (host_text.size() > 0) host_text.push_back(".");
          add_label($urandom_range(1, 8));
        end
      end else if (kind < 30) add_long_hostname();
      else if (kind < 45) add_dotted_quad();
      else if (kind < 65) add_hex_groups();
      else if (kind < 80) add_v6_dotted();
      else repeat ($urandom_range(1, 8)) host_text.push_back(pick_noise());
      // guard against an empty string before sending
      if (host_text.size() == 0) host_text.push_back(pick_noise());
      if (kind < 80 && $urandom_range(0, 4) == 0) mutate_text();
      send_text(BY_MODEL);
      if ($urandom_range(0, 39) == 0) hold_until_drained();
    end

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d strings in %0d bytes, %0d mismatches", strings_sent, bytes_sent,
             fail_count);
    $display("tb_top: verdicts hostname %0d, ipv4 %0d, ipv6 %0d, rejected %0d",
             n_host, n_ipv4, n_ipv6, n_none);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
